FILE: rtl/assert_macros.svh
// assertion macros used by the rtl datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge out of reset
`define KPAC_ASSERT(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define KPAC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: rtl/kpac_pkg.sv
// types, constants and codes shared by the keypad pin access controller
`default_nettype none

package kpac_pkg;

    localparam int MAX_ACCOUNTS = 5;
    // account index and account count widths
    localparam int IDX_W = $clog2(MAX_ACCOUNTS);
    localparam int CNT_W = $clog2(MAX_ACCOUNTS + 1);

    localparam logic [15:0] PIN_RESET0 = 16'h1234;
    localparam logic [15:0] PIN_RESET1 = 16'h1357;
    localparam logic [15:0] PIN_EMPTY  = 16'hFFFF;

    localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
    localparam logic [3:0] KEY_ADD       = 4'd10;
    localparam logic [3:0] KEY_HIST      = 4'd12;

    localparam logic [3:0] ST_TICK      = 4'd0;
    localparam logic [3:0] ST_DIGIT     = 4'd1;
    localparam logic [3:0] ST_LOGIN_OK  = 4'd2;
    localparam logic [3:0] ST_LOGIN_BAD = 4'd3;
    localparam logic [3:0] ST_ADDED     = 4'd4;
    localparam logic [3:0] ST_ADD_MODE  = 4'd5;
    localparam logic [3:0] ST_FULL      = 4'd6;
    localparam logic [3:0] ST_LOGOUT    = 4'd7;
    localparam logic [3:0] ST_RECORD    = 4'd8;
    localparam logic [3:0] ST_IGNORED   = 4'd9;

    typedef struct packed {
        logic       command;
        logic [3:0] key;
    } in_item_t;

    typedef struct packed {
        logic [3:0] status;
        logic [2:0] account;
        logic [6:0] bcd_seconds;
        logic [6:0] bcd_minutes;
        logic [5:0] bcd_hours;
        logic [7:0] login_count;
        logic       logged_in;
        logic       adding;
        logic [1:0] digit_count;
        logic       last;
    } out_item_t;

    // datapath commands issued by the controller
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LATCH,
        OP_EXEC,
        OP_STEP,
        OP_HIT,
        OP_MISS,
        OP_REC
    } op_t;

    // kind of request held in the datapath
    typedef enum logic [2:0] {
        CL_TICK,
        CL_DIGIT,
        CL_ADD,
        CL_CHECK,
        CL_ADDMODE,
        CL_CANCEL,
        CL_REPORT,
        CL_IGNORE
    } class_t;

    typedef struct packed {
        class_t cls;
        logic   scan_hit;
        logic   scan_end;
        logic   rec_last;
        logic   out_free;
    } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/kpac_ctrl.sv
// controller state machine sequencing requests through the datapath
`default_nettype none

module kpac_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire kpac_pkg::dp_status_t status,
    output kpac_pkg::op_t            op
);
    import kpac_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_REPORT
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        op         = OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op         = OP_LATCH;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (status.cls == CL_CHECK)
                begin
                    state_next = S_SCAN;
                end
                else if (status.cls == CL_REPORT)
                begin
                    state_next = S_REPORT;
                end
                else if (status.out_free)
                begin
                    op         = OP_EXEC;
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                // one table entry compared per cycle
                priority if (status.scan_end)
                begin
                    if (status.out_free)
                    begin
                        op         = OP_MISS;
                        state_next = S_IDLE;
                    end
                end
                else if (status.scan_hit)
                begin
                    if (status.out_free)
                    begin
                        op         = OP_HIT;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    op = OP_STEP;
                end
            end
            S_REPORT:
            begin
                if (status.out_free)
                begin
                    op = OP_REC;
                    if (status.rec_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/kpac_datapath.sv
// datapath: clock, account tables, pin entry and output register
`default_nettype none

`include "assert_macros.svh"

module kpac_datapath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire kpac_pkg::in_item_t  in_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [7:0]          cfg_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output kpac_pkg::out_item_t      out_data,
    input  wire kpac_pkg::op_t       op,
    output kpac_pkg::dp_status_t     status
);
    import kpac_pkg::*;

    localparam logic [7:0] MIN_WRAP  = 8'h60;
    localparam logic [7:0] HOUR_WRAP = 8'h24;

    logic [7:0]       tps_reg;
    logic [7:0]       tick_reg, tick_next;
    logic [7:0]       sec_reg, sec_next;
    logic [7:0]       min_reg, min_next;
    logic [7:0]       hour_reg, hour_next;
    logic [15:0]      pin_tab_reg [MAX_ACCOUNTS];
    logic [23:0]      stamp_tab_reg [MAX_ACCOUNTS];
    logic [7:0]       count_tab_reg [MAX_ACCOUNTS];
    logic [CNT_W-1:0] used_reg, used_next;
    logic [15:0]      entered_reg, entered_next;
    logic [1:0]       held_reg, held_next;
    logic             session_reg, session_next;
    logic             add_reg, add_next;
    in_item_t         item_reg, item_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    out_item_t        out_reg, out_next;
    logic             out_valid_reg, out_valid_next;

    class_t           cls;
    logic             load;
    logic             full;
    logic             out_free;
    logic [IDX_W-1:0] sel;
    logic [IDX_W-1:0] wsel;
    logic [15:0]      pin_full;
    logic [15:0]      pin_sel;
    logic [23:0]      stamp_sel;
    logic [7:0]       count_sel;
    logic [7:0]       count_inc;
    logic [23:0]      now;
    logic [7:0]       adv_sec, adv_min, adv_hour;
    logic [3:0]       nib_sh;
    logic             add_write;
    logic             hit_write;

    function automatic logic [7:0] bcd_fix(input logic [7:0] v);
        logic [8:0] s;
        s = {1'b0, v} + 9'd6;
        if (v[3:0] >= 4'd10)
        begin
            return {s[7:4], 4'h0};
        end
        return v;
    endfunction

    function automatic out_item_t mk_out(
        input logic [3:0]  st,
        input logic [2:0]  acct,
        input logic [23:0] stamp,
        input logic [7:0]  cnt,
        input logic        lg,
        input logic        ad,
        input logic [1:0]  dg,
        input logic        lst
    );
        out_item_t o;
        o.status      = st;
        o.account     = acct;
        o.bcd_seconds = stamp[6:0];
        o.bcd_minutes = stamp[14:8];
        o.bcd_hours   = stamp[21:16];
        o.login_count = cnt;
        o.logged_in   = lg;
        o.adding      = ad;
        o.digit_count = dg;
        o.last        = lst;
        return o;
    endfunction

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign out_free  = !out_valid_reg || out_ready;
    assign full      = (used_reg >= CNT_W'(MAX_ACCOUNTS));
    assign sel       = idx_reg[IDX_W-1:0];
    assign wsel      = used_reg[IDX_W-1:0];
    assign pin_sel   = pin_tab_reg[sel];
    assign stamp_sel = stamp_tab_reg[sel];
    assign count_sel = count_tab_reg[sel];
    assign count_inc = count_sel + 8'd1;
    assign pin_full  = {entered_reg[15:4], item_reg.key};
    assign now       = {hour_reg, min_reg, sec_reg};
    // first digit sits in the top nibble
    assign nib_sh    = {~held_reg, 2'b00};

    // request classification from the held item and session state
    always_comb
    begin
        priority if (!item_reg.command)
        begin
            cls = CL_TICK;
        end
        else if (item_reg.key <= KEY_DIGIT_MAX)
        begin
            if (held_reg != 2'd3)
            begin
                cls = CL_DIGIT;
            end
            else if (add_reg)
            begin
                cls = CL_ADD;
            end
            else
            begin
                cls = CL_CHECK;
            end
        end
        else if (item_reg.key == KEY_ADD && session_reg)
        begin
            cls = CL_ADDMODE;
        end
        else if (item_reg.key == KEY_HIST && session_reg)
        begin
            cls = add_reg ? CL_CANCEL : CL_REPORT;
        end
        else
        begin
            cls = CL_IGNORE;
        end
    end

    assign status.cls      = cls;
    assign status.scan_end = (idx_reg >= used_reg);
    assign status.scan_hit = (pin_sel == pin_full);
    assign status.rec_last = ((idx_reg + CNT_W'(1)) == used_reg);
    assign status.out_free = out_free;

    // one-second advance of the bcd clock
    always_comb
    begin
        adv_sec  = bcd_fix(sec_reg + 8'd1);
        adv_min  = min_reg;
        adv_hour = hour_reg;
        if (adv_sec == MIN_WRAP)
        begin
            adv_sec = 8'd0;
            adv_min = bcd_fix(min_reg + 8'd1);
            if (adv_min == MIN_WRAP)
            begin
                adv_min  = 8'd0;
                adv_hour = bcd_fix(hour_reg + 8'd1);
                if (adv_hour == HOUR_WRAP)
                begin
                    adv_hour = 8'd0;
                    adv_min  = 8'd0;
                    adv_sec  = 8'd0;
                end
            end
        end
    end

    always_comb
    begin
        tick_next    = tick_reg;
        sec_next     = sec_reg;
        min_next     = min_reg;
        hour_next    = hour_reg;
        used_next    = used_reg;
        entered_next = entered_reg;
        held_next    = held_reg;
        session_next = session_reg;
        add_next     = add_reg;
        item_next    = item_reg;
        idx_next     = idx_reg;
        out_next     = out_reg;
        load         = 1'b0;
        add_write    = 1'b0;
        hit_write    = 1'b0;
        unique case (op)
            OP_LATCH:
            begin
                item_next = in_data;
                idx_next  = '0;
            end
            OP_STEP:
            begin
                idx_next = idx_reg + CNT_W'(1);
            end
            OP_REC:
            begin
                load     = 1'b1;
                idx_next = idx_reg + CNT_W'(1);
                out_next = mk_out(ST_RECORD, 3'(idx_reg), stamp_sel, count_sel,
                                  session_reg, add_reg, held_reg, status.rec_last);
            end
            OP_HIT:
            begin
                load         = 1'b1;
                hit_write    = 1'b1;
                session_next = 1'b1;
                held_next    = 2'd0;
                entered_next = PIN_EMPTY;
                out_next     = mk_out(ST_LOGIN_OK, 3'(idx_reg), now, count_inc,
                                      1'b1, add_reg, 2'd0, 1'b1);
            end
            OP_MISS:
            begin
                load         = 1'b1;
                held_next    = 2'd0;
                entered_next = PIN_EMPTY;
                out_next     = mk_out(ST_LOGIN_BAD, 3'd0, now, 8'd0,
                                      session_reg, add_reg, 2'd0, 1'b1);
            end
            OP_EXEC:
            begin
                load = 1'b1;
                unique case (cls)
                    CL_TICK:
                    begin
                        tick_next = tick_reg + 8'd1;
                        if (tick_next >= tps_reg)
                        begin
                            tick_next = 8'd0;
                            sec_next  = adv_sec;
                            min_next  = adv_min;
                            hour_next = adv_hour;
                        end
                        out_next = mk_out(ST_TICK, 3'd0, {hour_next, min_next, sec_next},
                                          8'd0, session_reg, add_reg, held_reg, 1'b1);
                    end
                    CL_DIGIT:
                    begin
                        entered_next = (entered_reg & ~(16'hF << nib_sh))
                                     | (16'(item_reg.key) << nib_sh);
                        held_next    = held_reg + 2'd1;
                        out_next     = mk_out(ST_DIGIT, 3'd0, now, 8'd0,
                                              session_reg, add_reg, held_next, 1'b1);
                    end
                    CL_ADD:
                    begin
                        held_next    = 2'd0;
                        entered_next = PIN_EMPTY;
                        add_next     = 1'b0;
                        if (!full)
                        begin
                            add_write = 1'b1;
                            used_next = used_reg + CNT_W'(1);
                        end
                        out_next = mk_out(ST_ADDED, full ? 3'd0 : 3'(used_reg), now, 8'd0,
                                          session_reg, 1'b0, 2'd0, 1'b1);
                    end
                    CL_ADDMODE:
                    begin
                        if (!full)
                        begin
                            add_next = 1'b1;
                        end
                        out_next = mk_out(full ? ST_FULL : ST_ADD_MODE, 3'd0, now, 8'd0,
                                          session_reg, add_next, held_reg, 1'b1);
                    end
                    CL_CANCEL:
                    begin
                        add_next     = 1'b0;
                        session_next = 1'b0;
                        out_next     = mk_out(ST_LOGOUT, 3'd0, now, 8'd0,
                                              1'b0, 1'b0, held_reg, 1'b1);
                    end
                    default:
                    begin
                        out_next = mk_out(ST_IGNORED, 3'd0, now, 8'd0,
                                          session_reg, add_reg, held_reg, 1'b1);
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg       <= 8'd1;
            tick_reg      <= 8'd0;
            sec_reg       <= 8'd0;
            min_reg       <= 8'd0;
            hour_reg      <= 8'd0;
            used_reg      <= CNT_W'(2);
            entered_reg   <= PIN_EMPTY;
            held_reg      <= 2'd0;
            session_reg   <= 1'b0;
            add_reg       <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_ACCOUNTS; i++)
            begin
                stamp_tab_reg[i] <= 24'd0;
                count_tab_reg[i] <= 8'd0;
                if (i == 0)
                begin
                    pin_tab_reg[i] <= PIN_RESET0;
                end
                else if (i == 1)
                begin
                    pin_tab_reg[i] <= PIN_RESET1;
                end
                else
                begin
                    pin_tab_reg[i] <= 16'd0;
                end
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                tps_reg <= cfg_data;
            end
            tick_reg      <= tick_next;
            sec_reg       <= sec_next;
            min_reg       <= min_next;
            hour_reg      <= hour_next;
            used_reg      <= used_next;
            entered_reg   <= entered_next;
            held_reg      <= held_next;
            session_reg   <= session_next;
            add_reg       <= add_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            if (add_write)
            begin
                pin_tab_reg[wsel]   <= pin_full;
                stamp_tab_reg[wsel] <= 24'd0;
                count_tab_reg[wsel] <= 8'd0;
            end
            if (hit_write)
            begin
                stamp_tab_reg[sel] <= now;
                count_tab_reg[sel] <= count_inc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        out_reg  <= out_next;
    end

    `KPAC_ASSERT_IMPL(a_load_slot_free, load, out_free, "result loaded over a pending result")
    `KPAC_ASSERT_IMPL(a_add_needs_session, add_reg, session_reg, "add mode outside a session")
    `KPAC_ASSERT(a_used_range, (used_reg >= CNT_W'(2)) && (used_reg <= CNT_W'(MAX_ACCOUNTS)), "account count out of range")
    `KPAC_ASSERT_IMPL(a_hit_in_table, op == OP_HIT || op == OP_REC, idx_reg < used_reg, "table access beyond used accounts")

endmodule

`default_nettype wire

FILE: rtl/keypad_pin_access_controller.sv
// top level of the keypad pin access controller
// Each request is a timer tick or a key press and yields one result, or one
// history record per account for the history key. A tick, a digit, the add key,
// a cancel or an ignored key is accepted, then executed into the output
// register. A fourth digit that checks a PIN is accepted, then compared with
// the table entries in turn until one matches or the table ends, since the
// single comparator walks the account table one entry per cycle. The history
// key loads one record per account, one record leaving the output register
// per cycle while the output is not stalled. A new request is accepted while
// the previous result still waits in the output register; a stalled output
// holds the sequencer until the register frees.
`default_nettype none

module keypad_pin_access_controller (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire kpac_pkg::in_item_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output kpac_pkg::out_item_t      out_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [7:0]          cfg_data
);
    import kpac_pkg::*;

    op_t        op;
    dp_status_t status;

    kpac_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .op       (op)
    );

    kpac_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .op        (op),
        .status    (status)
    );

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// testbench for the keypad pin access controller: request stimulus, result prediction and checks
`timescale 1ns / 1ps

module tb_top;
    import kpac_pkg::*;

    localparam int IDLE_CYCLES = 16;
    localparam logic [7:0] SEC_WRAP = 8'h60;
    localparam logic [7:0] HOUR_WRAP = 8'h24;

    // predicts every result of the controller and checks them in order
    class access_ledger;
        logic [7:0] rate;
        logic [7:0] sec;
        logic [7:0] minutes;
        logic [7:0] hrs;
        logic [7:0] prescale;
        logic [15:0] pins [MAX_ACCOUNTS];
        logic [23:0] stamps [MAX_ACCOUNTS];
        logic [7:0] counts [MAX_ACCOUNTS];
        int unsigned used;
        logic [15:0] entry;
        logic [1:0] held;
        bit open_session;
        bit add_pending;
        out_item_t pending_results [$];
        int unsigned fails;
        int unsigned checked;

        function new();
            rate = 8'd1;
            sec = '0;
            minutes = '0;
            hrs = '0;
            prescale = '0;
            for (int i = 0; i < MAX_ACCOUNTS; i++)
            begin
                pins[i] = '0;
                stamps[i] = '0;
                counts[i] = '0;
            end
            pins[0] = PIN_RESET0;
            pins[1] = PIN_RESET1;
            used = 2;
            entry = PIN_EMPTY;
            held = '0;
            open_session = 1'b0;
            add_pending = 1'b0;
            fails = 0;
            checked = 0;
        endfunction

        function logic [7:0] bcd_inc(logic [7:0] v);
            logic [7:0] w;
            logic [8:0] t;
            w = v + 8'd1;
            if (w[3:0] >= 4'd10)
            begin
                t = {1'b0, w} + 9'd6;
                return {t[7:4], 4'h0};
            end
            return w;
        endfunction

        function void next_second();
            sec = bcd_inc(sec);
            if (sec == SEC_WRAP)
            begin
                sec = '0;
                minutes = bcd_inc(minutes);
                if (minutes == SEC_WRAP)
                begin
                    minutes = '0;
                    hrs = bcd_inc(hrs);
                    // midnight clears the whole clock
                    if (hrs == HOUR_WRAP)
                    begin
                        hrs = '0;
                        minutes = '0;
                        sec = '0;
                    end
                end
            end
        endfunction

        function logic [23:0] now_stamp();
            return {hrs, minutes, sec};
        endfunction

        function void push(logic [3:0] st, int unsigned acct, logic [23:0] stamp,
                           logic [7:0] cnt);
            out_item_t o;
            o.status = st;
            o.account = 3'(acct);
            o.bcd_seconds = stamp[6:0];
            o.bcd_minutes = stamp[14:8];
            o.bcd_hours = stamp[21:16];
            o.login_count = cnt;
            o.logged_in = open_session;
            o.adding = add_pending;
            o.digit_count = held;
            o.last = 1'b0;
            pending_results.push_back(o);
        endfunction

        // returns 1 when the request does more than get ignored
        function bit apply_request(in_item_t req);
            int unsigned pos;
            int unsigned idx;
            logic [15:0] pin;
            bit hit;
            bit acted;
            out_item_t tail;
            acted = 1'b1;
            if (!req.command)
            begin
                prescale = prescale + 8'd1;
                if (prescale >= rate)
                begin
                    prescale = '0;
                    next_second();
                end
                push(ST_TICK, 0, now_stamp(), '0);
            end
            else if (req.key <= KEY_DIGIT_MAX)
            begin
                pos = held;
                entry[(3 - pos) * 4 +: 4] = req.key;
                if (pos < 3)
                begin
                    held = 2'(pos + 1);
                    push(ST_DIGIT, 0, now_stamp(), '0);
                end
                else
                begin
                    pin = entry;
                    held = '0;
                    entry = PIN_EMPTY;
                    if (add_pending)
                    begin
                        add_pending = 1'b0;
                        if (used < MAX_ACCOUNTS)
                        begin
                            idx = used;
                            pins[idx] = pin;
                            stamps[idx] = '0;
                            counts[idx] = '0;
                            used++;
                            push(ST_ADDED, idx, now_stamp(), '0);
                        end
                        else
                            push(ST_ADDED, 0, now_stamp(), '0);
                    end
                    else
                    begin
                        hit = 1'b0;
                        idx = 0;
                        // first match wins
                        for (int unsigned j = 0; j < used; j++)
                        begin
                            if (!hit && pins[j] == pin)
                            begin
                                hit = 1'b1;
                                idx = j;
                            end
                        end
                        if (hit)
                        begin
                            stamps[idx] = now_stamp();
                            counts[idx] = counts[idx] + 8'd1;
                            open_session = 1'b1;
                            push(ST_LOGIN_OK, idx, now_stamp(), counts[idx]);
                        end
                        else
                            push(ST_LOGIN_BAD, 0, now_stamp(), '0);
                    end
                end
            end
            else if (req.key == KEY_ADD && open_session)
            begin
                if (used < MAX_ACCOUNTS)
                begin
                    add_pending = 1'b1;
                    push(ST_ADD_MODE, 0, now_stamp(), '0);
                end
                else
                    push(ST_FULL, 0, now_stamp(), '0);
            end
            else if (req.key == KEY_HIST && open_session)
            begin
                if (add_pending)
                begin
                    add_pending = 1'b0;
                    open_session = 1'b0;
                    push(ST_LOGOUT, 0, now_stamp(), '0);
                end
                else
                begin
                    for (int unsigned j = 0; j < used; j++)
                        push(ST_RECORD, j, stamps[j], counts[j]);
                end
            end
            else
            begin
                push(ST_IGNORED, 0, now_stamp(), '0);
                acted = 1'b0;
            end
            tail = pending_results.pop_back();
            tail.last = 1'b1;
            pending_results.push_back(tail);
            return acted;
        endfunction

        task report_mismatch(string msg);
            fails++;
            $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        task compare_field(string name, logic [7:0] got, logic [7:0] want, logic [3:0] st);
            if (got !== want)
                report_mismatch($sformatf("%s got %0h want %0h (expected status %0d)",
                                          name, got, want, st));
        endtask

        task match_result(out_item_t got);
            out_item_t want;
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("result with nothing expected, status %0d",
                                          got.status));
                return;
            end
            want = pending_results.pop_front();
            checked++;
            compare_field("status", 8'(got.status), 8'(want.status), want.status);
            compare_field("account", 8'(got.account), 8'(want.account), want.status);
            compare_field("bcd_seconds", 8'(got.bcd_seconds), 8'(want.bcd_seconds),
                          want.status);
            compare_field("bcd_minutes", 8'(got.bcd_minutes), 8'(want.bcd_minutes),
                          want.status);
            compare_field("bcd_hours", 8'(got.bcd_hours), 8'(want.bcd_hours), want.status);
            compare_field("login_count", got.login_count, want.login_count, want.status);
            compare_field("logged_in", 8'(got.logged_in), 8'(want.logged_in), want.status);
            compare_field("adding", 8'(got.adding), 8'(want.adding), want.status);
            compare_field("digit_count", 8'(got.digit_count), 8'(want.digit_count),
                          want.status);
            compare_field("last", 8'(got.last), 8'(want.last), want.status);
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_item_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_item_t out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [7:0] cfg_data = '0;

    access_ledger ledger = new();
    int unsigned requests_sent = 0;
    int unsigned counted_items = 0;
    bit steady = 1'b0;

    keypad_pin_access_controller dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // valid may stay high into the next request when no gap is drawn
    task automatic send_request(bit cmd, logic [3:0] k);
        in_item_t req;
        int gap;
        req.command = cmd;
        req.key = k;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= req;
        do @(posedge clk); while (in_ready !== 1'b1);
        if (ledger.apply_request(req))
            counted_items++;
        requests_sent++;
    endtask

    task automatic press(logic [3:0] k);
        send_request(1'b1, k);
    endtask

    task automatic tick();
        send_request(1'b0, 4'($urandom_range(0, 15)));
    endtask

    task automatic enter_pin(logic [15:0] pin);
        for (int i = 0; i < 4; i++)
            press(pin[15 - 4 * i -: 4]);
    endtask

    function automatic logic [15:0] random_pin();
        logic [15:0] pin;
        for (int i = 0; i < 4; i++)
            pin[4 * i +: 4] = 4'($urandom_range(0, 9));
        return pin;
    endfunction

    function automatic logic [15:0] known_pin();
        return ledger.pins[$urandom_range(0, ledger.used - 1)];
    endfunction

    task automatic finish_digits();
        while (ledger.held != 0)
            press(4'($urandom_range(0, 9)));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (ledger.pending_results.size() != 0)
            @(posedge clk);
        repeat (IDLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_rate(logic [7:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        ledger.rate = v;
    endtask

    task automatic try_login();
        finish_digits();
        if ($urandom_range(0, 9) < 7)
            enter_pin(known_pin());
        else
            enter_pin(random_pin());
    endtask

    task automatic try_add();
        int n;
        logic [15:0] pin;
        finish_digits();
        if (!ledger.open_session)
            enter_pin(known_pin());
        press(KEY_ADD);
        if (ledger.add_pending)
        begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : 4;
            // a copied pin makes the first match win later
            pin = ($urandom_range(0, 3) == 0) ? known_pin() : random_pin();
            for (int i = 0; i < n; i++)
                press(pin[15 - 4 * i -: 4]);
            if (n < 4)
                press(KEY_HIST);
        end
    endtask

    task automatic random_mix(int unsigned target);
        int unsigned stop_at;
        int r;
        stop_at = counted_items + target;
        while (counted_items < stop_at)
        begin
            if ($urandom_range(0, 7) == 0)
                steady = !steady;
            r = $urandom_range(0, 99);
            if (r < 30)
                try_login();
            else if (r < 45)
                try_add();
            else if (r < 55)
                press(KEY_HIST);
            else if (r < 72)
                repeat ($urandom_range(1, 6)) tick();
            else if (r < 86)
                press(4'($urandom_range(10, 15)));
            else
                send_request(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
        end
        steady = 1'b0;
    endtask

    task automatic directed_checks();
        send_request(1'b0, 4'hF);
        send_request(1'b0, 4'h0);
        press(4'd11);
        press(4'd13);
        press(4'd14);
        press(4'd15);
        // add and history keys do nothing while logged out
        press(KEY_ADD);
        press(KEY_HIST);
        enter_pin(16'h9999);
        press(4'd1);
        press(4'd2);
        press(4'd11);
        press(KEY_HIST);
        press(4'd3);
        press(4'd4);
        press(KEY_HIST);
        press(KEY_ADD);
        press(KEY_ADD);
        enter_pin(16'h0000);
        // cancel add mode with a digit held, then finish a login with it
        press(KEY_ADD);
        press(4'd1);
        press(KEY_HIST);
        press(4'd3);
        press(4'd5);
        press(4'd7);
    endtask

    // result side: random stalls per result
    initial
    begin
        int gap;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            gap = steady ? 0 : $urandom_range(0, 4);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (out_valid !== 1'b1);
            ledger.match_result(out_data);
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        write_rate(8'd0);
        directed_checks();
        // every tick is a second here, so this carries into the first minute
        repeat (60) tick();
        drain();

        write_rate(8'($urandom_range(2, 9)));
        random_mix(22);
        drain();

        write_rate(8'd255);
        random_mix(22);
        drain();

        write_rate(8'd1);
        random_mix(22);
        drain();

        $display("sent %0d requests (%0d acted on), checked %0d results",
                 requests_sent, counted_items, ledger.checked);
        $display("prescale 0, 1, 255 and one mid value; %0d accounts; clock now %h:%h:%h",
                 ledger.used, ledger.hrs, ledger.minutes, ledger.sec);
        if (ledger.fails == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("timeout with %0d results outstanding", ledger.pending_results.size());
        $display("TB_ERROR");
        $finish;
    end

endmodule
